// ----- rtl/gfba_pkg.sv -----
`default_nettype none

package gfba_pkg;

    localparam int GROUP      = 16;
    localparam int NUM_BLOCKS = 256;

    localparam int BLK_W      = 8;
    localparam int SP_W       = $clog2(GROUP);
    localparam int CNT_W      = $clog2(NUM_BLOCKS + 1);
    localparam int LINK_DEPTH = NUM_BLOCKS;
    localparam int LINK_AW    = $clog2(NUM_BLOCKS);

    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FREE  = 1'b1;

    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    typedef logic [GROUP-1:0][BLK_W-1:0] t_group;

    typedef struct packed {
        logic             mode;
        logic [BLK_W-1:0] block_number;
    } t_req;

    typedef struct packed {
        logic [BLK_W-1:0] allocated_block;
        logic             status;
    } t_rsp;

    typedef struct packed {
        logic               rd_en;
        logic               wr_en;
        logic [LINK_AW-1:0] addr;
        t_group             wdata;
    } t_link_req;

    function automatic t_group stack_reset_value();
        t_group v;
        for (int i = 0; i < GROUP; i++) begin
            v[i] = BLK_W'(NUM_BLOCKS - 1 - i);
        end
        return v;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/gfba_link_mem.sv -----
`default_nettype none

module gfba_link_mem
    import gfba_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_link_req i_req,
    output t_group         o_rdata
);

    t_group                  r_mem [LINK_DEPTH];
    logic [LINK_DEPTH-1:0]   r_vld;
    t_group                  r_rdata;
    logic                    r_rvld;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.addr] <= i_req.wdata;
        end
        if (i_req.rd_en) begin
            r_rdata <= r_mem[i_req.addr];
        end
    end

    // A group that was never written reads as all zeros.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_rvld <= 1'b0;
        end else begin
            if (i_req.wr_en) begin
                r_vld[i_req.addr] <= 1'b1;
            end
            if (i_req.rd_en) begin
                r_rvld <= r_vld[i_req.addr];
            end
        end
    end

    assign o_rdata = r_rvld ? r_rdata : '0;

endmodule

`default_nettype wire

// ----- rtl/grouped_free_block_allocator.sv -----
// Latency: a result is offered in the cycle after its request transfer.
// Throughput: one request per cycle while the output is not stalled, except
// an allocate that takes the last stack entry, after which the refill state
// reloads the stack from the link memory read while new requests stall.
// Reset (synchronous, active low) restores the initial stack, pointer and free
// count and marks every link group as all zeros.
`default_nettype none

module grouped_free_block_allocator
    import gfba_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    output logic      o_stall,
    input  wire t_req i_req,
    output logic      o_valid,
    input  wire logic i_stall,
    output t_rsp      o_rsp
);

    typedef enum logic [1:0] {
        S_IDLE   = 2'b01,
        S_REFILL = 2'b10
    } t_state;

    t_state            r_state;
    t_group            r_stack;
    logic [SP_W-1:0]   r_sp;
    logic [CNT_W-1:0]  r_count;
    logic              r_out_valid;
    t_rsp              r_out;

    t_link_req         n_link;
    t_group            link_rdata;
    logic              accept;
    logic [BLK_W-1:0]  got;

    assign o_stall = (r_state != S_IDLE) || (r_out_valid && i_stall);
    assign accept  = i_valid && !o_stall;
    assign got     = r_stack[r_sp];

    always_comb begin
        n_link       = '0;
        n_link.wdata = r_stack;
        if (accept) begin
            if (i_req.mode == MODE_ALLOC) begin
                n_link.addr  = LINK_AW'(got);
                n_link.rd_en = (r_count != '0) && (r_sp == SP_W'(GROUP - 1));
            end else begin
                n_link.addr  = LINK_AW'(i_req.block_number);
                n_link.wr_en = (r_sp == '0);
            end
        end
    end

    gfba_link_mem u_link_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (n_link),
        .o_rdata (link_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_stack     <= stack_reset_value();
            r_sp        <= '0;
            r_count     <= CNT_W'(NUM_BLOCKS - 3);
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        if (i_req.mode == MODE_ALLOC) begin
                            if (r_count != '0) begin
                                r_count <= r_count - 1'b1;
                                if (r_sp == SP_W'(GROUP - 1)) begin
                                    r_sp    <= '0;
                                    r_state <= S_REFILL;
                                end else begin
                                    r_sp <= r_sp + 1'b1;
                                end
                            end
                        end else begin
                            r_sp          <= r_sp - 1'b1;
                            r_stack[r_sp - 1'b1] <= i_req.block_number;
                            if (r_count != CNT_W'(NUM_BLOCKS)) begin
                                r_count <= r_count + 1'b1;
                            end
                        end
                    end
                end
                S_REFILL: begin
                    r_stack <= link_rdata;
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            if (i_req.mode == MODE_ALLOC) begin
                if (r_count == '0) begin
                    r_out.allocated_block <= '0;
                    r_out.status          <= STATUS_FULL;
                end else begin
                    r_out.allocated_block <= got;
                    r_out.status          <= STATUS_OK;
                end
            end else begin
                r_out.allocated_block <= '0;
                r_out.status          <= STATUS_OK;
            end
        end
    end

    assign o_valid = r_out_valid;
    assign o_rsp   = r_out;

endmodule

`default_nettype wire
